FILE: src/four_neighbour_smoothing_filter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the four-neighbour smoothing filter
// Shared helpers that wrap concurrent assertions clocked on clk with rst_n.
// ---------------------------------------------------------------------------
`ifndef FOUR_NEIGHBOUR_SMOOTHING_FILTER_DEFINES_SVH
`define FOUR_NEIGHBOUR_SMOOTHING_FILTER_DEFINES_SVH

// The condition must hold at every clock edge out of reset.
`define FNSF_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define FNSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fnsf_pkg.sv
// ---------------------------------------------------------------------------
// fnsf_pkg
// Types and fixed constants shared by the smoothing filter modules.
// ---------------------------------------------------------------------------
package fnsf_pkg;

  localparam int PIX_W     = 8;
  localparam int FW_W      = 11;
  localparam int FH_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 16'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // Position flags of one pixel, fixed when the pixel is accepted.
  typedef struct packed {
    logic has_prev;  // a row above exists, so a result for it is due
    logic interior;  // the row above is filtered at this column
    logic last_row;  // this pixel is also echoed as a result
    logic row_end;   // last column of the row
  } pos_flags_t;

  typedef struct packed {
    pix_t pixel;
    logic done;
  } result_t;

endpackage

FILE: src/fnsf_ram.sv
// ---------------------------------------------------------------------------
// fnsf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module fnsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/fnsf_pos.sv
// ---------------------------------------------------------------------------
// fnsf_pos
// Column and row counters of the input stream and per-pixel position flags.
// ---------------------------------------------------------------------------
module fnsf_pos #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fnsf_pkg::FW_W-1:0]   frame_width,
  input  logic [fnsf_pkg::FH_W-1:0]   frame_height,
  input  logic                        advance,
  output logic [CW-1:0]               col,
  output logic [CW-1:0]               col_east,
  output fnsf_pkg::pos_flags_t        flags
);

  localparam int EW = (CW + 1 > fnsf_pkg::FW_W) ? CW + 1 : fnsf_pkg::FW_W;

  logic [CW-1:0]             col_r, col_nxt;
  logic [fnsf_pkg::FH_W-1:0] row_r, row_nxt;
  logic [EW-1:0]             fw_e, eff_w, x_e;
  logic [fnsf_pkg::FH_W-1:0] last_row_idx;

  always_comb begin
    fw_e = EW'(frame_width);
    // A zero width acts as one; widths beyond the line store saturate.
    if (fw_e == '0) begin
      eff_w = EW'(1);
    end else if (fw_e > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = fw_e;
    end
    x_e = EW'(col_r);
    last_row_idx = (frame_height == '0) ? '0 : frame_height - 16'd1;

    flags.has_prev = (row_r != '0);
    flags.interior = (row_r >= 16'd2) && (col_r != '0) && ((x_e + EW'(2)) <= eff_w);
    flags.last_row = (row_r >= last_row_idx);
    flags.row_end  = ((x_e + EW'(1)) >= eff_w);
  end

  assign col      = col_r;
  assign col_east = (col_r == CW'(MAX_WIDTH - 1)) ? col_r : col_r + CW'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (flags.row_end) begin
        col_nxt = '0;
        row_nxt = flags.last_row ? '0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: src/fnsf_kernel.sv
// ---------------------------------------------------------------------------
// fnsf_kernel
// Four-neighbour mean of one pixel of the row above, and the echo result.
// ---------------------------------------------------------------------------
module fnsf_kernel (
  input  fnsf_pkg::pix_t       pix,
  input  fnsf_pkg::pix_t       centre,
  input  fnsf_pkg::pix_t       north,
  input  fnsf_pkg::pix_t       west,
  input  fnsf_pkg::pix_t       east,
  input  fnsf_pkg::pos_flags_t flags,
  output fnsf_pkg::result_t    res_a,
  output logic                 want_a,
  output fnsf_pkg::result_t    res_b,
  output logic                 want_b
);

  fnsf_pkg::pix_t sum;

  // Each quarter is at most 63, so the sum stays within eight bits.
  assign sum = {2'b00, north[7:2]} + {2'b00, pix[7:2]}
             + {2'b00, west[7:2]}  + {2'b00, east[7:2]};

  assign res_a.pixel = flags.interior ? sum : centre;
  assign res_a.done  = 1'b0;
  assign want_a      = flags.has_prev;

  assign res_b.pixel = pix;
  assign res_b.done  = flags.row_end;
  assign want_b      = flags.last_row;

endmodule

FILE: src/fnsf_outq.sv
// ---------------------------------------------------------------------------
// fnsf_outq
// Two-entry result queue that takes up to two results from one pixel.
// ---------------------------------------------------------------------------
module fnsf_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fnsf_pkg::result_t res_a,
  input  logic              want_a,
  input  fnsf_pkg::result_t res_b,
  input  logic              want_b,
  input  logic              out_ready,
  output logic              out_valid,
  output fnsf_pkg::result_t head,
  output logic [1:0]        space
);

  fnsf_pkg::result_t slots_r [2];
  fnsf_pkg::result_t slots_nxt [2];
  logic [1:0]        cnt_r, cnt_nxt;
  logic              pop;
  logic [1:0]        idx;

  assign out_valid = (cnt_r != 2'd0);
  assign head      = slots_r[0];
  assign pop       = out_valid && out_ready;
  // Room counts the slot freed by a beat leaving in this cycle.
  assign space     = 2'd2 - cnt_r + {1'b0, pop};

  always_comb begin
    slots_nxt = slots_r;
    if (pop) begin
      slots_nxt[0] = slots_r[1];
    end
    idx = cnt_r - {1'b0, pop};
    if (push && want_a) begin
      slots_nxt[idx[0]] = res_a;
      idx = idx + 2'd1;
    end
    if (push && want_b) begin
      slots_nxt[idx[0]] = res_b;
      idx = idx + 2'd1;
    end
    cnt_nxt = idx;
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/four_neighbour_smoothing_filter.sv
// ---------------------------------------------------------------------------
// four_neighbour_smoothing_filter
// One smoothing pass over a raster-order greyscale frame, one row behind.
// ---------------------------------------------------------------------------
// The block accepts one pixel per clock cycle while the output queue has
// room for the results of the pixel in the input stage. Each pixel waits
// in the input stage, where the line stores have already been read, and
// its results enter a two-entry output queue as it leaves that stage. Up
// to the next-to-last row that rate holds; on the last row a pixel yields
// two results (one if the frame has one row) and the single result port
// sets the pace. The previous row is held twice (one copy per read port,
// centre and east neighbour) and the row above that once, each a MAX_WIDTH
// by 8 RAM with registered read; no clearing pass is run after reset.
// The result for (x, y-1) is queued when (x, y) leaves the input stage.
module four_neighbour_smoothing_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fnsf_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fnsf_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                           out_frame_done,
  input  logic                           cfg_we,
  input  logic [fnsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fnsf_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [fnsf_pkg::FW_W-1:0] cfg_width_r;
  logic [fnsf_pkg::FH_W-1:0] cfg_height_r;

  logic                 accept;
  logic [CW-1:0]        col, col_east;
  fnsf_pkg::pos_flags_t flags;

  logic                 s1_valid_r;
  fnsf_pkg::pix_t       s1_pix_r;
  fnsf_pkg::pos_flags_t s1_flags_r;
  logic [CW-1:0]        s1_col_r;
  logic                 s1_fire;
  logic [1:0]           need, space;

  fnsf_pkg::pix_t prev_c_q, prev_e_q, older_q;
  fnsf_pkg::pix_t centre, east, north, west_r;
  logic           byp_c_r, byp_e_r, byp_o_r;
  fnsf_pkg::pix_t byp_pix_r, byp_cen_r;
  logic           older_we;

  fnsf_pkg::result_t res_a, res_b, head;
  logic              want_a, want_b;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= fnsf_pkg::FW_RESET;
      cfg_height_r <= fnsf_pkg::FH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fnsf_pkg::CFG_FRAME_WIDTH:  cfg_width_r  <= cfg_data[fnsf_pkg::FW_W-1:0];
        fnsf_pkg::CFG_FRAME_HEIGHT: cfg_height_r <= cfg_data[fnsf_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  assign need     = {1'b0, s1_flags_r.has_prev} + {1'b0, s1_flags_r.last_row};
  assign s1_fire  = s1_valid_r && (need <= space);
  assign in_ready = !s1_valid_r || s1_fire;
  assign accept   = in_valid && in_ready;

  fnsf_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (cfg_width_r),
    .frame_height (cfg_height_r),
    .advance      (accept),
    .col          (col),
    .col_east     (col_east),
    .flags        (flags)
  );

  // Line stores are read when a pixel is taken and written when it leaves
  // the input stage.
  assign older_we = s1_fire && s1_flags_r.has_prev;

  fnsf_ram #(.WIDTH(fnsf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_prev_c (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (col),
    .rdata (prev_c_q)
  );

  fnsf_ram #(.WIDTH(fnsf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_prev_e (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (col_east),
    .rdata (prev_e_q)
  );

  fnsf_ram #(.WIDTH(fnsf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (older_we),
    .waddr (s1_col_r),
    .wdata (centre),
    .re    (accept),
    .raddr (col),
    .rdata (older_q)
  );

  // On very narrow frames a read can hit the entry written in the same
  // cycle; the written value is forwarded instead of the stale RAM word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_c_r <= 1'b0;
      byp_e_r <= 1'b0;
      byp_o_r <= 1'b0;
    end else if (accept) begin
      byp_c_r <= s1_fire && (s1_col_r == col);
      byp_e_r <= s1_fire && (s1_col_r == col_east);
      byp_o_r <= older_we && (s1_col_r == col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_pix_r <= s1_pix_r;
      byp_cen_r <= centre;
    end
  end

  assign centre = byp_c_r ? byp_pix_r : prev_c_q;
  assign east   = byp_e_r ? byp_pix_r : prev_e_q;
  assign north  = byp_o_r ? byp_cen_r : older_q;

  // The west neighbour is the centre of the pixel just before in the row.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      west_r <= centre;
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_pixel_in;
      s1_flags_r <= flags;
      s1_col_r   <= col;
    end
  end

  fnsf_kernel u_kernel (
    .pix    (s1_pix_r),
    .centre (centre),
    .north  (north),
    .west   (west_r),
    .east   (east),
    .flags  (s1_flags_r),
    .res_a  (res_a),
    .want_a (want_a),
    .res_b  (res_b),
    .want_b (want_b)
  );

  fnsf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_fire),
    .res_a     (res_a),
    .want_a    (want_a),
    .res_b     (res_b),
    .want_b    (want_b),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .space     (space)
  );

  assign out_pixel_out  = head.pixel;
  assign out_frame_done = head.done;

`include "four_neighbour_smoothing_filter_defines.svh"

  `FNSF_ASSERT_NEXT(a_col_wrap, accept && flags.row_end, col == '0, "column did not wrap at row end")
  `FNSF_ASSERT_NEXT(a_frame_wrap, accept && flags.row_end && flags.last_row, !flags.has_prev, "row did not wrap at frame end")
  `FNSF_ASSERT_HOLD(a_mean_range, !(s1_valid_r && s1_flags_r.interior) || (res_a.pixel <= 8'd252), "filtered pixel above 252")

endmodule

FILE: tb/tb_four_neighbour_smoothing_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_four_neighbour_smoothing_filter
// Streams greyscale frames through the smoothing filter and checks every
// result beat against a predictor that keeps its own line stores, position
// counters and register copies. Frame geometry is changed between frames and
// changed mid-frame while the block is idle. The sender pauses between bursts
// and the receiver stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module tb_four_neighbour_smoothing_filter;

  localparam int MAX_W          = 1024;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 60;

  logic                           clk;
  logic                           rst_n        = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_ready;
  logic [fnsf_pkg::PIX_W-1:0]     in_pixel_in  = '0;
  logic                           out_valid;
  logic                           out_ready    = 1'b0;
  logic [fnsf_pkg::PIX_W-1:0]     out_pixel_out;
  logic                           out_frame_done;
  logic                           cfg_we       = 1'b0;
  logic [fnsf_pkg::CFG_IDX_W-1:0] cfg_index    = fnsf_pkg::CFG_FRAME_WIDTH;
  logic [fnsf_pkg::CFG_W-1:0]     cfg_data     = '0;

  // Predictor state: register copies, line stores and the input position.
  logic [fnsf_pkg::FW_W-1:0] width_reg  = fnsf_pkg::FW_RESET;
  logic [fnsf_pkg::FH_W-1:0] height_reg = fnsf_pkg::FH_RESET;
  fnsf_pkg::pix_t            line_above  [MAX_W];
  fnsf_pkg::pix_t            line_two_up [MAX_W];
  int unsigned               col_pos = 0;
  int unsigned               row_pos = 0;
  fnsf_pkg::result_t         due_pixels[$];

  int mismatches   = 0;
  int sent_count   = 0;
  int stuck_cycles = 0;
  int stall_mode   = 0;
  int stall_phase  = 0;
  int gap_limit    = 0;
  int burst_left   = 0;

  four_neighbour_smoothing_filter #(.MAX_WIDTH(MAX_W)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_done (out_frame_done),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  // Works out the results that one accepted pixel causes.
  function automatic void smooth_step(input fnsf_pkg::pix_t pix);
    int unsigned       w;
    int unsigned       h;
    int unsigned       x;
    int unsigned       y;
    bit                last_row;
    bit                row_end;
    fnsf_pkg::pix_t    centre;
    logic [9:0]        sum;
    fnsf_pkg::result_t res;
    w        = eff_width();
    h        = eff_height();
    x        = col_pos;
    y        = row_pos;
    last_row = (y + 1 >= h);
    row_end  = (x + 1 >= w);
    if (x >= MAX_W) x = MAX_W - 1;
    if (y >= 1) begin
      centre = line_above[x];
      sum    = {2'b00, centre};
      // The west neighbour of the row above has already moved to line_two_up.
      if (y >= 2 && x >= 1 && x + 2 <= w) begin
        sum = 10'(line_two_up[x] >> 2) + 10'(pix >> 2) + 10'(line_two_up[x-1] >> 2)
            + 10'(line_above[x+1] >> 2);
      end
      res.pixel = sum[7:0];
      res.done  = 1'b0;
      due_pixels.insert(due_pixels.size(), res);
      line_two_up[x] = centre;
    end
    line_above[x] = pix;
    if (last_row) begin
      res.pixel = pix;
      res.done  = row_end;
      due_pixels.insert(due_pixels.size(), res);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Input prediction, register tracking and result checking.
  always @(posedge clk) begin
    fnsf_pkg::result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) smooth_step(in_pixel_in);
      if (cfg_we) begin
        case (cfg_index)
          fnsf_pkg::CFG_FRAME_WIDTH:  width_reg  = cfg_data[fnsf_pkg::FW_W-1:0];
          fnsf_pkg::CFG_FRAME_HEIGHT: height_reg = cfg_data[fnsf_pkg::FH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_pixels.size() == 0) begin
          $display("%0t: result beat with none due: pixel %0d done %0b",
                   $time, out_pixel_out, out_frame_done);
          mismatches++;
        end else begin
          want = due_pixels[0];
          due_pixels.delete(0);
          if (out_pixel_out !== want.pixel) begin
            $display("%0t: pixel_out expected %0d actual %0d",
                     $time, want.pixel, out_pixel_out);
            mismatches++;
          end
          if (out_frame_done !== want.done) begin
            $display("%0t: frame_done expected %0b actual %0b",
                     $time, want.done, out_frame_done);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver stall patterns.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ((stall_phase % 7) < 4);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_four_neighbour_smoothing_filter: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic fnsf_pkg::pix_t noisy_pixel();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input fnsf_pkg::pix_t pix);
    int gap;
    if (burst_left == 0) begin
      gap        = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_pixels(input int unsigned count);
    repeat (count) send_pixel(noisy_pixel());
  endtask

  // Stops the sender and waits until every due result has been checked.
  task automatic wait_idle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_geometry(input bit set_w, input logic [fnsf_pkg::CFG_W-1:0] w_val,
                              input bit set_h, input logic [fnsf_pkg::CFG_W-1:0] h_val);
    if (set_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= fnsf_pkg::CFG_FRAME_WIDTH;
      cfg_data  <= w_val;
      @(posedge clk);
    end
    if (set_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= fnsf_pkg::CFG_FRAME_HEIGHT;
      cfg_data  <= h_val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    // Lets the register copies settle before use.
    @(posedge clk);
  endtask

  // Sends the rest of the current frame under the present geometry.
  task automatic finish_frame();
    int unsigned w;
    int unsigned h;
    int unsigned count;
    w     = eff_width();
    h     = eff_height();
    count = (col_pos + 1 >= w) ? 1 : w - col_pos;
    if (row_pos + 1 < h) count += (h - 1 - row_pos) * w;
    send_pixels(count);
  endtask

  // Most of a row under the reset geometry, then the row is made the last
  // one with a width that saturates to the line store size.
  task automatic test_reset_geometry();
    stall_mode = 1;
    gap_limit  = 2;
    send_pixels(MAX_W - 24);
    wait_idle(4);
    set_geometry(1'b1, 16'hFFFF, 1'b1, 16'd1);
    finish_frame();
  endtask

  // A width and a height shrunk part way through a frame.
  task automatic test_mid_frame_resize();
    wait_idle(4);
    set_geometry(1'b1, 16'd16, 1'b1, 16'hFFFF);
    send_pixels(29);
    wait_idle(4);
    // Column 13 lies beyond the new width, so the next pixel ends the row.
    set_geometry(1'b1, 16'd8, 1'b0, '0);
    send_pixels(13);
    wait_idle(4);
    set_geometry(1'b0, '0, 1'b1, 16'd4);
    finish_frame();
  endtask

  task automatic test_degenerate_sizes();
    wait_idle(4);
    set_geometry(1'b1, 16'd0, 1'b1, 16'd0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    wait_idle(4);
    // Bits above the width register must be ignored, giving width 3.
    set_geometry(1'b1, 16'h0803, 1'b1, 16'd1);
    send_pixel(8'h80);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    wait_idle(4);
    set_geometry(1'b1, 16'd2, 1'b1, 16'd2);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  task automatic test_interior_extremes();
    stall_mode = 2;
    wait_idle(4);
    set_geometry(1'b1, 16'd3, 1'b1, 16'd3);
    repeat (9) send_pixel(8'hFF);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);
  endtask

  task automatic test_random_frames();
    int          start;
    int unsigned w;
    int unsigned h;
    int unsigned frame_size;
    start = sent_count;
    while (sent_count - start < RANDOM_ITEMS) begin
      stall_mode = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
        0:       gap_limit = 0;
        1:       gap_limit = 2;
        default: gap_limit = 8;
      endcase
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) w = 0;
      if ($urandom_range(0, 19) == 0) h = 0;
      wait_idle(4);
      set_geometry(1'b1, {5'($urandom_range(0, 31)), 11'(w)}, 1'b1, 16'(h));
      if ($urandom_range(0, 9) < 3) begin
        // Cut the frame short: shrink width or change height part way in.
        frame_size = eff_width() * eff_height();
        send_pixels($urandom_range(1, frame_size));
        wait_idle(4);
        if ($urandom_range(0, 1))
          set_geometry(1'b1, 16'($urandom_range(1, eff_width())), 1'b0, '0);
        else
          set_geometry(1'b0, '0, 1'b1, 16'($urandom_range(0, eff_height() + 2)));
      end
      finish_frame();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_mid_frame_resize();
    test_degenerate_sizes();
    test_interior_extremes();
    test_random_frames();
    wait_idle(16);
    if (mismatches == 0) begin
      $display("tb_four_neighbour_smoothing_filter: PASS");
    end else begin
      $display("tb_four_neighbour_smoothing_filter: FAIL");
    end
    $finish;
  end

endmodule
